// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the stable priority job queue.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int TAG_W        = 8;
    localparam int PRIO_W       = 8;
    localparam int FUNC_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int OCC_W        = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 3'd0,
        FUNC_POP    = 3'd1,
        FUNC_RUN    = 3'd2,
        FUNC_REMOVE = 3'd3,
        FUNC_CLEAR  = 3'd4,
        FUNC_STOP   = 3'd5
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_STOPPED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // per-cell update command
    typedef struct packed {
        logic push;
        logic shift;
    } cell_ctl_t;

endpackage

// ===== design/spq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted job chain: holds a tag and a priority, takes the
// new job, its left neighbor on an insert, or its right neighbor on a removal.
// ---------------------------------------------------------------------------
module spq_cell
(
    input  logic                        clk,
    input  spq_pkg::cell_ctl_t          ctl,
    input  logic                        occupied,
    input  logic [spq_pkg::TAG_W-1:0]   new_tag,
    input  logic [spq_pkg::PRIO_W-1:0]  new_prio,
    input  logic [spq_pkg::TAG_W-1:0]   left_tag,
    input  logic [spq_pkg::PRIO_W-1:0]  left_prio,
    input  logic                        left_gt,
    input  logic [spq_pkg::TAG_W-1:0]   right_tag,
    input  logic [spq_pkg::PRIO_W-1:0]  right_prio,
    output logic [spq_pkg::TAG_W-1:0]   tag,
    output logic [spq_pkg::PRIO_W-1:0]  prio,
    output logic                        gt
);

    logic [spq_pkg::TAG_W-1:0]  tag_reg;
    logic [spq_pkg::TAG_W-1:0]  tag_next;
    logic [spq_pkg::PRIO_W-1:0] prio_reg;
    logic [spq_pkg::PRIO_W-1:0] prio_next;

    // strictly greater keeps equal priorities in arrival order
    assign gt   = occupied && (prio_reg > new_prio);
    assign tag  = tag_reg;
    assign prio = prio_reg;

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctl.push)
        begin
            if (left_gt)
            begin
                tag_next  = left_tag;
                prio_next = left_prio;
            end
            else if (gt || !occupied)
            begin
                tag_next  = new_tag;
                prio_next = new_prio;
            end
        end
        else if (ctl.shift)
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

endmodule

// ===== design/stable_priority_job_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stable_priority_job_queue
// Bounded priority queue of job tags kept sorted in a chain of cells.
// ---------------------------------------------------------------------------
// An operation (push, pop, remove, clear or stop) is taken in the idle state
// and carried out in the execute state once the result register is free; a
// pop of the front priority run sends one job per cycle after that while the
// result register is free. The chain of cells updates all slots at once in
// the execute state, and the one-entry result register sets the pace of a run
// under back pressure. The smallest priority leaves first, equal priorities
// leave in arrival order, and a push into a full or stopped queue is dropped
// with a status code.
// ---------------------------------------------------------------------------
module stable_priority_job_queue
#(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [spq_pkg::FUNC_W-1:0]      func,
    input  logic [spq_pkg::TAG_W-1:0]       job_tag,
    input  logic [spq_pkg::PRIO_W-1:0]      job_priority,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [spq_pkg::TAG_W-1:0]       out_tag,
    output logic [spq_pkg::PRIO_W-1:0]      out_priority,
    output logic [spq_pkg::STATUS_W-1:0]    status,
    output logic                            last,
    output logic                            now_empty,
    output logic [spq_pkg::OCC_W-1:0]       occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic                           stopped_reg;
    logic                           stopped_next;

    logic [spq_pkg::FUNC_W-1:0]     func_reg;
    logic [spq_pkg::TAG_W-1:0]      tag_reg;
    logic [spq_pkg::PRIO_W-1:0]     prio_reg;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [spq_pkg::TAG_W-1:0]      out_tag_reg;
    logic [spq_pkg::TAG_W-1:0]      out_tag_next;
    logic [spq_pkg::PRIO_W-1:0]     out_prio_reg;
    logic [spq_pkg::PRIO_W-1:0]     out_prio_next;
    spq_pkg::status_t               out_status_reg;
    spq_pkg::status_t               out_status_next;
    logic                           out_last_reg;
    logic                           out_last_next;
    logic                           out_empty_reg;
    logic                           out_empty_next;
    logic [spq_pkg::OCC_W-1:0]      out_occ_reg;
    logic [spq_pkg::OCC_W-1:0]      out_occ_next;

    logic [spq_pkg::TAG_W-1:0]      cell_tag  [CAPACITY];
    logic [spq_pkg::PRIO_W-1:0]     cell_prio [CAPACITY];
    logic [CAPACITY-1:0]            cell_gt;
    logic [CAPACITY-1:0]            cell_occ;
    logic [CAPACITY-1:0]            match_vec;
    logic [CAPACITY-1:0]            rm_shift;
    logic [CAPACITY-1:0]            shift_vec;
    logic                           push_en;
    logic                           found;
    logic                           out_free;
    logic                           in_xfer;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign found     = |match_vec;

    // ---- cell chain ----
    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            spq_pkg::cell_ctl_t ctl;
            logic [spq_pkg::TAG_W-1:0]  l_tag;
            logic [spq_pkg::PRIO_W-1:0] l_prio;
            logic                       l_gt;
            logic [spq_pkg::TAG_W-1:0]  r_tag;
            logic [spq_pkg::PRIO_W-1:0] r_prio;

            assign cell_occ[i]  = (count_reg > CW'(i));
            assign match_vec[i] = cell_occ[i] && (cell_tag[i] == tag_reg);
            // first match and everything behind it moves up one slot
            assign rm_shift[i]  = |match_vec[i:0];
            assign ctl.push     = push_en;
            assign ctl.shift    = shift_vec[i];

            if (i == 0)
            begin : g_head
                assign l_tag  = '0;
                assign l_prio = '0;
                assign l_gt   = 1'b0;
            end
            else
            begin : g_body
                assign l_tag  = cell_tag[i-1];
                assign l_prio = cell_prio[i-1];
                assign l_gt   = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign r_tag  = cell_tag[i];
                assign r_prio = cell_prio[i];
            end
            else
            begin : g_mid
                assign r_tag  = cell_tag[i+1];
                assign r_prio = cell_prio[i+1];
            end

            spq_cell u_cell
            (
                .clk        (clk),
                .ctl        (ctl),
                .occupied   (cell_occ[i]),
                .new_tag    (tag_reg),
                .new_prio   (prio_reg),
                .left_tag   (l_tag),
                .left_prio  (l_prio),
                .left_gt    (l_gt),
                .right_tag  (r_tag),
                .right_prio (r_prio),
                .tag        (cell_tag[i]),
                .prio       (cell_prio[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    // ---- control ----
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        stopped_next    = stopped_reg;
        push_en         = 1'b0;
        shift_vec       = '0;
        out_valid_next  = out_valid_reg && !out_ready;
        out_tag_next    = out_tag_reg;
        out_prio_next   = out_prio_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        out_occ_next    = out_occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (func inside {spq_pkg::FUNC_PUSH, spq_pkg::FUNC_POP,
                    spq_pkg::FUNC_RUN, spq_pkg::FUNC_REMOVE, spq_pkg::FUNC_CLEAR,
                    spq_pkg::FUNC_STOP}))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    out_valid_next  = 1'b1;
                    out_tag_next    = '0;
                    out_prio_next   = '0;
                    out_status_next = spq_pkg::ST_DONE;
                    out_last_next   = 1'b1;
                    case (func_reg)
                        spq_pkg::FUNC_PUSH:
                        begin
                            if (stopped_reg)
                            begin
                                out_status_next = spq_pkg::ST_STOPPED;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                out_status_next = spq_pkg::ST_FULL;
                            end
                            else
                            begin
                                push_en    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        spq_pkg::FUNC_POP,
                        spq_pkg::FUNC_RUN:
                        begin
                            if (count_reg == '0)
                            begin
                                out_status_next = spq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                shift_vec     = '1;
                                count_next    = count_reg - 1'b1;
                                out_tag_next  = cell_tag[0];
                                out_prio_next = cell_prio[0];
                                if (func_reg == spq_pkg::FUNC_RUN)
                                begin
                                    out_last_next = (count_reg == CW'(1)) ||
                                                    (cell_prio[1] != cell_prio[0]);
                                    if (!out_last_next)
                                    begin
                                        state_next = S_EXEC;
                                    end
                                end
                            end
                        end
                        spq_pkg::FUNC_REMOVE:
                        begin
                            if (found)
                            begin
                                shift_vec  = rm_shift;
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                out_status_next = spq_pkg::ST_NOT_FOUND;
                            end
                        end
                        spq_pkg::FUNC_CLEAR:
                        begin
                            count_next = '0;
                        end
                        spq_pkg::FUNC_STOP:
                        begin
                            count_next   = '0;
                            stopped_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && !out_ready;
                        end
                    endcase
                    out_empty_next = (count_next == '0);
                    out_occ_next   = spq_pkg::OCC_W'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg <= func;
            tag_reg  <= job_tag;
            prio_reg <= job_priority;
        end
        out_tag_reg    <= out_tag_next;
        out_prio_reg   <= out_prio_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
        out_empty_reg  <= out_empty_next;
        out_occ_reg    <= out_occ_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_tag      = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign status       = out_status_reg;
    assign last         = out_last_reg;
    assign now_empty    = out_empty_reg;
    assign occupancy    = out_occ_reg;

endmodule
